// ===== hdl/tbt_pkg.sv =====
// Shared types and constants for the trailing blank line trimmer.
`timescale 1ns / 1ps
package tbt_pkg;

	localparam int CHAR_W    = 8;
	localparam int LIMIT_W   = 7;
	localparam int LINE_NO_W = 16;

	localparam logic [CHAR_W-1:0]    CH_SPACE    = 8'h20;
	localparam logic [CHAR_W-1:0]    CH_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0]    CH_NEWLINE  = 8'h0A;
	localparam logic [CHAR_W-1:0]    CH_NULL     = 8'h00;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 7'd64;
	localparam logic [LIMIT_W-1:0]   LIMIT_MIN   = 7'd2;
	localparam logic [LINE_NO_W-1:0] LINE_NO_MAX = 16'hFFFF;

	// Controller states
	typedef enum logic [1:0] {
		ST_RUN,
		ST_EMIT,
		ST_ERR,
		ST_HALT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic store;        // buffer the incoming character
		logic finish;       // close the line: bump line number, clear counts
		logic start_replay; // reset replay index, read first entry
		logic emit_char;    // load buffered character into output, read next
		logic emit_nl;      // load closing newline into output
		logic emit_err;     // load error result into output
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_newline;
		logic overflow;
		logic fill_nz;
		logic kept_nz;
		logic idx_done;
		logic slot_free;
	} sts_t;

endpackage

// ===== hdl/tbt_if.sv =====
// Valid/ready channel interfaces for characters in and results out.
`timescale 1ns / 1ps
interface tbt_in_if import tbt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;
	logic              end_of_input;

	modport source (output valid, output char_in, output end_of_input, input ready);
	modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface tbt_out_if import tbt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CHAR_W-1:0]    out_char;
	logic                 is_error;
	logic [LINE_NO_W-1:0] error_line;
	logic                 last_of_run;

	modport source (output valid, output out_char, output is_error, output error_line,
		output last_of_run, input ready);
	modport sink   (input valid, input out_char, input is_error, input error_line,
		input last_of_run, output ready);
endinterface

// ===== hdl/tbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, hold data when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/tbt_datapath.sv =====
// Line buffer, counters, limit register and output register of the trimmer.
`timescale 1ns / 1ps
module tbt_datapath import tbt_pkg::*; #(
	parameter int MAX_LINE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [LIMIT_W-1:0]   cfg_wdata,
	input  logic [CHAR_W-1:0]    char_in,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [CHAR_W-1:0]    out_char,
	output logic                 out_is_error,
	output logic [LINE_NO_W-1:0] out_error_line,
	output logic                 out_last
);

	localparam int CNT_W  = $clog2(MAX_LINE + 1);
	localparam int ADDR_W = $clog2(MAX_LINE);
	localparam int CMP_W  = LIMIT_W + 1;

	logic [LIMIT_W-1:0]   limit_q;
	logic [CNT_W-1:0]     fill_q;
	logic [CNT_W-1:0]     kept_q;
	logic [CNT_W-1:0]     idx_q;
	logic [LINE_NO_W-1:0] line_no_q;
	logic                 ovalid_q;

	logic [CNT_W-1:0]     fill_nxt;
	logic [CNT_W-1:0]     idx_nxt;
	logic [CMP_W-1:0]     fill_ext;
	logic [CMP_W-1:0]     eff_limit;
	logic [LINE_NO_W-1:0] line_no_inc;
	logic [CHAR_W-1:0]    rdata;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic                 is_blank;

	assign fill_nxt    = fill_q + 1'b1;
	assign idx_nxt     = idx_q + 1'b1;
	assign fill_ext    = CMP_W'(fill_q);
	assign line_no_inc = (line_no_q == LINE_NO_MAX) ? line_no_q : line_no_q + 1'b1;
	assign is_blank    = (char_in == CH_SPACE) || (char_in == CH_TAB);

	// Clamp the configured limit to the supported range
	always_comb begin
		priority if (limit_q < LIMIT_MIN) begin
			eff_limit = CMP_W'(LIMIT_MIN);
		end else if (CMP_W'(limit_q) > CMP_W'(MAX_LINE)) begin
			eff_limit = CMP_W'(MAX_LINE);
		end else begin
			eff_limit = CMP_W'(limit_q);
		end
	end

	// Status toward the controller
	assign sts.is_newline = (char_in == CH_NEWLINE);
	assign sts.overflow   = (fill_ext + 1'b1 >= eff_limit) || (fill_ext >= CMP_W'(MAX_LINE));
	assign sts.fill_nz    = (fill_q != '0);
	assign sts.kept_nz    = (kept_q != '0);
	assign sts.idx_done   = (idx_q == kept_q);
	assign sts.slot_free  = !ovalid_q || out_ready;

	// Line buffer: write at fill position, replay from index
	assign ram_re    = cmd.start_replay || cmd.emit_char;
	assign ram_raddr = cmd.start_replay ? '0 : idx_nxt[ADDR_W-1:0];

	tbt_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (MAX_LINE)
	) u_line_store (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (char_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Fill and kept counts, line number, replay index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			kept_q    <= '0;
			idx_q     <= '0;
			line_no_q <= '0;
		end else begin
			if (cmd.store) begin
				fill_q <= fill_nxt;
				if (!is_blank) begin
					kept_q <= fill_nxt;
				end
			end
			if (cmd.finish) begin
				fill_q    <= '0;
				kept_q    <= '0;
				line_no_q <= line_no_inc;
			end
			if (cmd.start_replay) begin
				idx_q <= '0;
			end else if (cmd.emit_char) begin
				idx_q <= idx_nxt;
			end
		end
	end

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit_char || cmd.emit_nl || cmd.emit_err) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.emit_char) begin
			out_char       <= rdata;
			out_is_error   <= 1'b0;
			out_error_line <= '0;
			out_last       <= 1'b0;
		end else if (cmd.emit_nl) begin
			out_char       <= CH_NEWLINE;
			out_is_error   <= 1'b0;
			out_error_line <= '0;
			out_last       <= 1'b1;
		end else if (cmd.emit_err) begin
			out_char       <= CH_NULL;
			out_is_error   <= 1'b1;
			out_error_line <= line_no_inc;
			out_last       <= 1'b1;
		end
	end

	assign out_valid = ovalid_q;

endmodule

// ===== hdl/tbt_ctrl.sv =====
// Controller state machine: accept, replay, error and halt sequencing.
`timescale 1ns / 1ps
module tbt_ctrl import tbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic end_of_input,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   halt_after_q, halt_after_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			halt_after_q <= 1'b0;
		end else begin
			state_q      <= state_nxt;
			halt_after_q <= halt_after_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt      = state_q;
		halt_after_nxt = halt_after_q;
		cmd            = '0;
		in_ready       = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				in_ready = 1'b1;
				if (in_valid) begin
					priority if (end_of_input) begin
						if (sts.kept_nz) begin
							cmd.start_replay = 1'b1;
							halt_after_nxt   = 1'b1;
							state_nxt        = ST_EMIT;
						end else begin
							cmd.finish = sts.fill_nz;
							state_nxt  = ST_HALT;
						end
					end else if (sts.is_newline) begin
						if (sts.kept_nz) begin
							cmd.start_replay = 1'b1;
							halt_after_nxt   = 1'b0;
							state_nxt        = ST_EMIT;
						end else begin
							cmd.finish = 1'b1;
						end
					end else if (sts.overflow) begin
						state_nxt = ST_ERR;
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				// Replay one buffered character per free output slot, then newline
				if (sts.slot_free) begin
					if (!sts.idx_done) begin
						cmd.emit_char = 1'b1;
					end else begin
						cmd.emit_nl = 1'b1;
						cmd.finish  = 1'b1;
						state_nxt   = halt_after_q ? ST_HALT : ST_RUN;
					end
				end
			end
			ST_ERR: begin
				if (sts.slot_free) begin
					cmd.emit_err = 1'b1;
					state_nxt    = ST_HALT;
				end
			end
			ST_HALT: begin
				// Drop everything until reset
				in_ready = 1'b1;
			end
			default: begin
				state_nxt = ST_HALT;
			end
		endcase
	end

endmodule

// ===== hdl/trailing_blank_line_trimmer.sv =====
// Top level of the trailing blank line trimmer.
// A character item, or an end-of-input item that closes nothing, is taken
// without holding the input. A newline, or end of input, that closes a line with
// visible characters holds the input while the line replays through the single
// read port of the line buffer, one result per cycle while the result channel
// does not stall; a blank line closes without holding the input. An overlong line
// gives one error transaction, after which the block, as after end of input,
// drops all input until reset. A result may wait in the output register while
// the next character transaction is taken. The user must write line_limit
// through cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
module trailing_blank_line_trimmer import tbt_pkg::*; #(
	parameter int MAX_LINE = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	tbt_in_if.sink             char_chan,
	tbt_out_if.source          result_chan
);

	cmd_t cmd;
	sts_t sts;

	// Sequencing
	tbt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (char_chan.valid),
		.end_of_input (char_chan.end_of_input),
		.in_ready     (char_chan.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// Buffer, counters and output register
	tbt_datapath #(
		.MAX_LINE (MAX_LINE)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.char_in        (char_chan.char_in),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (result_chan.ready),
		.out_valid      (result_chan.valid),
		.out_char       (result_chan.out_char),
		.out_is_error   (result_chan.is_error),
		.out_error_line (result_chan.error_line),
		.out_last       (result_chan.last_of_run)
	);

endmodule
